>>> src/sps_pkg.sv
// shared types and constants of the strict priority ready scheduler
// opcodes, status codes, register indexes and the controller/datapath interface
// no dependencies
package sps_pkg;

	localparam int ID_W     = 10;
	localparam int BAND_W   = 2;
	localparam int CREDIT_W = 16;
	localparam int LIMIT_W  = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 16;

	localparam int NUM_BANDS   = 4;
	localparam int QUEUE_COUNT = 1024;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;
	localparam logic [CREDIT_W-1:0] CREDIT_RESET = 16'd64;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CREDIT_GRANT = 1'b1;

	typedef enum logic [1:0] {
		OP_ACTIVATE   = 2'd0,
		OP_DEACTIVATE = 2'd1,
		OP_POP        = 2'd2,
		OP_UNUSED     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	typedef struct packed {
		logic    latch_in;
		logic    clr_step;
		logic    use_scan;
		logic    map_rd;
		logic    map_wr;
		logic    map_wr_val;
		logic    push;
		logic    pop_rd;
		logic    scan_next;
		logic    res_set;
		status_t res_code;
		logic    res_grant;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		op_t  op;
		logic req_bad;
		logic map_bit;
		logic fifo_full;
		logic scan_end;
		logic scan_empty;
		logic pop_hit;
		logic out_free;
	} sts_t;

endpackage

>>> src/sps_ctrl.sv
// controller state machine of the strict priority ready scheduler
// sequences bitmap clearing, activate/deactivate and the pop band scan
// depends on sps_pkg
module sps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sps_pkg::sts_t sts,
	output sps_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_CHECK  = 10'b0000000100,
		S_UPDATE = 10'b0000001000,
		S_SCAN   = 10'b0000010000,
		S_PMAP   = 10'b0000100000,
		S_PCHK   = 10'b0001000000,
		S_DONE   = 10'b0010000000,
		S_SPARE0 = 10'b0100000000,
		S_SPARE1 = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_code = sps_pkg::ST_OK;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.op == sps_pkg::OP_POP) begin
					state_d = S_SCAN;
				end else if (sts.req_bad) begin
					cmd.res_set = 1'b1;
					cmd.res_code = sps_pkg::ST_INVALID;
					state_d = S_DONE;
				end else begin
					cmd.map_rd = 1'b1;
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.res_set = 1'b1;
				state_d = S_DONE;
				priority if (sts.op == sps_pkg::OP_DEACTIVATE) begin
					cmd.map_wr = 1'b1;
				end else if (sts.map_bit) begin
					cmd.res_code = sps_pkg::ST_OK;
				end else if (sts.fifo_full) begin
					cmd.res_code = sps_pkg::ST_FULL;
				end else begin
					cmd.map_wr = 1'b1;
					cmd.map_wr_val = 1'b1;
					cmd.push = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.use_scan = 1'b1;
				priority if (sts.scan_end) begin
					cmd.res_set = 1'b1;
					cmd.res_code = sps_pkg::ST_NONE;
					state_d = S_DONE;
				end else if (sts.scan_empty) begin
					cmd.scan_next = 1'b1;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d = S_PMAP;
				end
			end
			S_PMAP: begin
				cmd.use_scan = 1'b1;
				cmd.map_rd = 1'b1;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				cmd.use_scan = 1'b1;
				if (sts.pop_hit) begin
					cmd.map_wr = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_grant = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result loaded over an untaken word");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.fifo_full)
		else $error("push into a full ready fifo");

endmodule

>>> src/sps_dp.sv
// datapath of the strict priority ready scheduler
// active bitmap and ready fifo memories, pointers, config and result register
// depends on sps_pkg
module sps_dp #(
	parameter int READY_DEPTH = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sps_pkg::cmd_t                      cmd,
	output sps_pkg::sts_t                      sts,
	input  logic [1:0]                         operation,
	input  logic [sps_pkg::ID_W-1:0]           queue_sel,
	input  logic [sps_pkg::BAND_W-1:0]         band,
	input  logic                               cfg_we,
	input  logic [sps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sps_pkg::CFG_W-1:0]          cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic [sps_pkg::ID_W-1:0]           granted_queue,
	output logic [sps_pkg::BAND_W-1:0]         granted_band,
	output logic [sps_pkg::CREDIT_W-1:0]       credit
);

	localparam int BW = $clog2(sps_pkg::NUM_BANDS);
	localparam int QW = $clog2(sps_pkg::QUEUE_COUNT);
	localparam int PW = $clog2(READY_DEPTH);
	localparam int MAW = BW + QW;
	localparam int MAP_DEPTH = 1 << MAW;
	localparam int SAW = BW + PW;
	localparam int STORE_DEPTH = 1 << SAW;
	localparam logic [16:0] MAXQ = 17'(sps_pkg::QUEUE_COUNT);
	localparam logic [PW-1:0] PTR_LAST = PW'(READY_DEPTH - 1);
	localparam logic [PW:0] CNT_FULL = (PW+1)'(READY_DEPTH);

	logic map_mem [MAP_DEPTH];
	logic [sps_pkg::ID_W-1:0] store_mem [STORE_DEPTH];

	logic [PW-1:0] head_q [sps_pkg::NUM_BANDS];
	logic [PW-1:0] tail_q [sps_pkg::NUM_BANDS];
	logic [PW:0]   cnt_q  [sps_pkg::NUM_BANDS];

	logic [sps_pkg::LIMIT_W-1:0]  limit_q;
	logic [sps_pkg::CREDIT_W-1:0] credit_q;
	logic [1:0]                   op_q;
	logic [sps_pkg::ID_W-1:0]     id_q;
	logic [sps_pkg::BAND_W-1:0]   band_q;
	logic [BW:0]                  sc_q;
	logic [MAW-1:0]               clr_q;
	logic                         map_q;
	logic [sps_pkg::ID_W-1:0]     pid_q;
	sps_pkg::status_t             res_q;
	logic                         grant_q;

	logic [16:0]    lim_eff;
	logic [BW-1:0]  bi;
	logic [BW-1:0]  si;
	logic [MAW-1:0] in_addr;
	logic [MAW-1:0] scan_addr;
	logic [MAW-1:0] map_addr;
	logic [MAW-1:0] map_wa;
	logic           map_we;
	logic           map_wd;

	assign lim_eff = (limit_q == '0 || 17'(limit_q) > MAXQ) ? MAXQ : 17'(limit_q);
	assign bi = BW'(band_q);
	assign si = sc_q[BW-1:0];
	assign in_addr = {bi, QW'(id_q)};
	assign scan_addr = {si, QW'(pid_q)};
	assign map_addr = cmd.use_scan ? scan_addr : in_addr;
	assign map_we = cmd.clr_step || cmd.map_wr;
	assign map_wa = cmd.clr_step ? clr_q : map_addr;
	assign map_wd = cmd.clr_step ? 1'b0 : cmd.map_wr_val;

	assign sts.clr_done   = (clr_q == '1);
	assign sts.op         = sps_pkg::op_t'(op_q);
	assign sts.req_bad    = (op_q == sps_pkg::OP_UNUSED)
		|| (int'(band_q) >= sps_pkg::NUM_BANDS) || (17'(id_q) >= lim_eff);
	assign sts.map_bit    = map_q;
	assign sts.fifo_full  = (cnt_q[bi] == CNT_FULL);
	assign sts.scan_end   = (int'(sc_q) >= sps_pkg::NUM_BANDS);
	assign sts.scan_empty = (cnt_q[si] == '0);
	assign sts.pop_hit    = (int'(pid_q) < sps_pkg::QUEUE_COUNT) && map_q;
	assign sts.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		if (cmd.map_rd) map_q <= map_mem[map_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) store_mem[{bi, tail_q[bi]}] <= id_q;
		if (cmd.pop_rd) pid_q <= store_mem[{si, head_q[si]}];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= operation;
			id_q <= queue_sel;
			band_q <= band;
		end
		if (cmd.res_set) begin
			res_q <= cmd.res_code;
			grant_q <= cmd.res_grant;
		end
		if (cmd.res_load) begin
			status <= res_q;
			granted_queue <= grant_q ? pid_q : '0;
			granted_band <= grant_q ? sps_pkg::BAND_W'(sc_q) : '0;
			credit <= grant_q ? credit_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sps_pkg::LIMIT_RESET;
			credit_q <= sps_pkg::CREDIT_RESET;
			clr_q <= '0;
			sc_q <= '0;
			out_valid <= 1'b0;
			for (int b = 0; b < sps_pkg::NUM_BANDS; b++) begin
				head_q[b] <= '0;
				tail_q[b] <= '0;
				cnt_q[b] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sps_pkg::REG_QUEUE_LIMIT:  limit_q <= cfg_data[sps_pkg::LIMIT_W-1:0];
					sps_pkg::REG_CREDIT_GRANT: credit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.latch_in) sc_q <= '0;
			else if (cmd.scan_next) sc_q <= sc_q + 1'b1;
			if (cmd.push) begin
				tail_q[bi] <= (tail_q[bi] == PTR_LAST) ? '0 : tail_q[bi] + 1'b1;
				cnt_q[bi] <= cnt_q[bi] + 1'b1;
			end
			if (cmd.pop_rd) begin
				head_q[si] <= (head_q[si] == PTR_LAST) ? '0 : head_q[si] + 1'b1;
				cnt_q[si] <= cnt_q[si] - 1'b1;
			end
			if (cmd.res_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

>>> src/strict_priority_ready_scheduler.sv
// Strict priority ready scheduler. After reset the block sweeps its active
// bitmap clear, one entry a cycle, all NUM_BANDS * QUEUE_COUNT (4096) entries
// and takes no word until then. One word is handled at a time. Activate and
// deactivate pass through a registered read-modify-write of the bitmap
// memory before the result register is set; an invalid word sets it directly.
// Pop skips each empty band and consumes the head of each other band (a ready
// fifo read followed by a bitmap read) until one is active and granted; when
// none is, the result is ST_NONE. A result still waiting to be taken holds
// the next one back. A new word is accepted while the previous result waits.
// top level; depends on sps_pkg, sps_ctrl and sps_dp
module strict_priority_ready_scheduler #(
	parameter int READY_DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic [sps_pkg::ID_W-1:0]          queue_sel,
	input  logic [sps_pkg::BAND_W-1:0]        band,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [sps_pkg::ID_W-1:0]          granted_queue,
	output logic [sps_pkg::BAND_W-1:0]        granted_band,
	output logic [sps_pkg::CREDIT_W-1:0]      credit,
	input  logic                              cfg_we,
	input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sps_pkg::CFG_W-1:0]         cfg_data
);

	sps_pkg::cmd_t cmd;
	sps_pkg::sts_t sts;

	sps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sps_dp #(
		.READY_DEPTH (READY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.queue_sel     (queue_sel),
		.band          (band),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_queue (granted_queue),
		.granted_band  (granted_band),
		.credit        (credit)
	);

endmodule
